/* design/sqmm_pkg.sv */
// sqmm_pkg: shared types and constants of the square matrix multiplier.
// No dependencies; used by sqmm_ctrl, sqmm_dp and square_matrix_multiply.
package sqmm_pkg;

   localparam int CSR_W      = 3;   // width of each size register
   localparam int CSR_IDX_W  = 1;   // width of the register index
   localparam int ELEM_W     = 16;  // width of one input element
   localparam int PROD_W     = 32;  // width of one product element
   localparam int IDX_OUT_W  = 2;   // width of result_row / result_column
   localparam int REQ_DATA_W = 16;  // req_tdata width, whole bytes
   localparam int RSP_DATA_W = 40;  // rsp_tdata width, whole bytes
   localparam int RSP_USER_W = 1;   // rsp_tuser width

   // pipeline depth between the last read issue and a settled accumulator
   localparam int DRAIN_CYCLES = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'd1;

   // register reset values
   localparam logic [CSR_W-1:0] ROW_COUNT_RESET    = 3'd4;
   localparam logic [CSR_W-1:0] COLUMN_COUNT_RESET = 3'd4;

   // controller to datapath commands
   typedef struct packed {
      logic wr_first;    // write element into the A store
      logic wr_second;   // write element into the B store
      logic issue;       // read one A/B pair for the multiply-accumulate
      logic acc_clear;   // first term of a new product element
      logic emit;        // load the result register
      logic emit_error;  // result is the size error transaction
      logic emit_last;   // result closes the run
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;    // result register can take a new transaction
   } dp_sts_type;

endpackage

/* design/square_matrix_multiply.sv */
// square_matrix_multiply: top level of the streaming square matrix multiplier.
// Depends on sqmm_pkg, sqmm_ctrl and sqmm_dp.
//
// The block takes signed 16-bit elements on the req_ stream, row-major: first
// rows*columns elements of matrix A, then as many of matrix B. A size register
// of 0 acts as 1 and one above MAX_SIZE acts as MAX_SIZE; any csr_ write
// restarts loading at the first A element. One element loads per valid cycle.
// After the last B element, a square size yields every C[i][j] = sum over k of
// A[i][k]*B[k][j] in row-major order, wrapped to 32 bits, with tlast on the
// final one; a non-square size yields a single transaction with the error flag
// and tlast set and zero data. Each product element passes the ISSUE, DRAIN
// and EMIT states: the single multiply-accumulate unit reads one A/B pair per
// cycle from the element stores, the pipeline drains, and the result register
// is loaded once it is free. The req_ side is stalled while products are being
// computed and reopens once the final result is in the output register, so the
// next matrix pair can load while that result waits to be taken.
module square_matrix_multiply #(
   parameter int MAX_SIZE = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [sqmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sqmm_pkg::CSR_W-1:0]           csr_wdata,
   // element stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sqmm_pkg::REQ_DATA_W-1:0]      req_tdata,  // [15:0] element_value
   // result stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [31:0] product_value, [33:32] result_row, [35:34] result_column, [39:36] zero
   output logic [sqmm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sqmm_pkg::RSP_USER_W-1:0]      rsp_tuser,  // [0] size_error
   output logic                                 rsp_tlast   // last_of_run
);

   localparam int SW = $clog2(MAX_SIZE + 1);
   localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

   sqmm_pkg::dp_cmd_type cmd;
   sqmm_pkg::dp_sts_type sts;
   logic [SW-1:0]        size;
   logic [IW-1:0]        row, col, k;
   logic [AW-1:0]        wr_addr;

   // sequence loading and the i/j/k loops
   sqmm_ctrl #(
      .MAX_SIZE (MAX_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .size       (size),
      .row        (row),
      .col        (col),
      .k          (k),
      .wr_addr    (wr_addr)
   );

   // hold the matrices, accumulate and drive the result transaction
   sqmm_dp #(
      .MAX_SIZE (MAX_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .size       (size),
      .row        (row),
      .col        (col),
      .k          (k),
      .wr_addr    (wr_addr),
      .wr_data    (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* design/sqmm_ctrl.sv */
// sqmm_ctrl: controller of the square matrix multiplier: size registers,
// load counter and the i/j/k sequencer. Depends on sqmm_pkg.
module sqmm_ctrl #(
   parameter int MAX_SIZE = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sqmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sqmm_pkg::CSR_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  sqmm_pkg::dp_sts_type              sts,
   output sqmm_pkg::dp_cmd_type              cmd,
   output logic [$clog2(MAX_SIZE+1)-1:0]     size,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] row,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] col,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] k,
   output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] wr_addr
);

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int SW    = $clog2(MAX_SIZE + 1);
   localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int AW    = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = $clog2(2 * DEPTH + 1);
   localparam int DCW   = (sqmm_pkg::DRAIN_CYCLES > 1) ?
                          $clog2(sqmm_pkg::DRAIN_CYCLES) : 1;

   typedef enum logic [1:0] {
      LOAD,
      ISSUE,
      DRAIN,
      EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [sqmm_pkg::CSR_W-1:0] row_count_ff, row_count_in;
   logic [sqmm_pkg::CSR_W-1:0] column_count_ff, column_count_in;
   logic [PW-1:0]              pos_ff, pos_in;
   logic [IW-1:0]              i_ff, i_in;
   logic [IW-1:0]              j_ff, j_in;
   logic [IW-1:0]              k_ff, k_in;
   logic [DCW-1:0]             drain_ff, drain_in;
   logic                       err_ff, err_in;

   logic [SW-1:0] rows, cols;
   logic [PW-1:0] total, total2;
   logic [IW-1:0] n_m1;
   logic          done;

   // clamp a size register into 1..MAX_SIZE
   function automatic logic [SW-1:0] eff_size(input logic [sqmm_pkg::CSR_W-1:0] v);
      logic [sqmm_pkg::CSR_W:0] v_x;
      logic [SW-1:0]            r;
      v_x = {1'b0, v};
      if (v_x == '0) begin
         r = SW'(1);
      end else if (v_x > (sqmm_pkg::CSR_W+1)'(MAX_SIZE)) begin
         r = SW'(MAX_SIZE);
      end else begin
         r = SW'(v_x);
      end
      return r;
   endfunction

   always_comb begin
      rows   = eff_size(row_count_ff);
      cols   = eff_size(column_count_ff);
      total  = PW'(rows) * PW'(cols);
      total2 = total << 1;
      n_m1   = IW'(rows - SW'(1));
   end

   assign req_tready = (state_ff == LOAD);
   assign size       = rows;
   assign row        = i_ff;
   assign col        = j_ff;
   assign k          = k_ff;
   assign wr_addr    = (pos_ff < total) ? AW'(pos_ff) : AW'(pos_ff - total);

   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      pos_in          = pos_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      k_in            = k_ff;
      drain_in        = drain_ff;
      err_in          = err_ff;
      cmd             = '0;
      done            = 1'b0;

      unique case (state_ff)
         LOAD: begin
            if (req_tvalid) begin
               cmd.wr_first  = (pos_ff < total);
               cmd.wr_second = !(pos_ff < total);
               if (pos_ff == total2 - PW'(1)) begin
                  pos_in = '0;
                  i_in   = '0;
                  j_in   = '0;
                  k_in   = '0;
                  if (rows != cols) begin
                     err_in   = 1'b1;
                     state_in = EMIT;
                  end else begin
                     err_in   = 1'b0;
                     state_in = ISSUE;
                  end
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
            end
         end
         ISSUE: begin
            cmd.issue     = 1'b1;
            cmd.acc_clear = (k_ff == '0);
            if (k_ff == n_m1) begin
               k_in     = '0;
               drain_in = '0;
               state_in = DRAIN;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         DRAIN: begin
            if (drain_ff == DCW'(sqmm_pkg::DRAIN_CYCLES - 1)) begin
               state_in = EMIT;
            end else begin
               drain_in = drain_ff + DCW'(1);
            end
         end
         EMIT: begin
            done = err_ff || ((i_ff == n_m1) && (j_ff == n_m1));
            if (sts.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_error = err_ff;
               cmd.emit_last  = done;
               if (done) begin
                  state_in = LOAD;
               end else begin
                  state_in = ISSUE;
                  if (j_ff == n_m1) begin
                     j_in = '0;
                     i_in = i_ff + IW'(1);
                  end else begin
                     j_in = j_ff + IW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = LOAD;
         end
      endcase

      // any size write restarts loading
      if (csr_we) begin
         pos_in = '0;
         unique case (csr_index)
            sqmm_pkg::CSR_ROW_COUNT:    row_count_in    = csr_wdata;
            sqmm_pkg::CSR_COLUMN_COUNT: column_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= LOAD;
         row_count_ff    <= sqmm_pkg::ROW_COUNT_RESET;
         column_count_ff <= sqmm_pkg::COLUMN_COUNT_RESET;
         pos_ff          <= '0;
         i_ff            <= '0;
         j_ff            <= '0;
         k_ff            <= '0;
         drain_ff        <= '0;
         err_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         pos_ff          <= pos_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         k_ff            <= k_in;
         drain_ff        <= drain_in;
         err_ff          <= err_in;
      end
   end

endmodule

/* design/sqmm_dp.sv */
// sqmm_dp: datapath of the square matrix multiplier: A and B element stores,
// multiply-accumulate pipeline and result register. Depends on sqmm_pkg.
module sqmm_dp #(
   parameter int MAX_SIZE = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sqmm_pkg::dp_cmd_type                 cmd,
   output sqmm_pkg::dp_sts_type                 sts,
   input  logic [$clog2(MAX_SIZE+1)-1:0]        size,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] row,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] col,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] k,
   input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE*MAX_SIZE) : 1)-1:0] wr_addr,
   input  logic [sqmm_pkg::ELEM_W-1:0]          wr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sqmm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sqmm_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;
   localparam int PAD_W = sqmm_pkg::RSP_DATA_W - sqmm_pkg::PROD_W
                          - 2 * sqmm_pkg::IDX_OUT_W;

   logic [sqmm_pkg::ELEM_W-1:0] first_store  [DEPTH];
   logic [sqmm_pkg::ELEM_W-1:0] second_store [DEPTH];

   logic [AW-1:0]                    rd_a_addr, rd_b_addr;
   logic [sqmm_pkg::ELEM_W-1:0]      a_q_ff, b_q_ff;
   logic                             rd_vld_ff, mul_vld_ff;
   logic                             clr_q_ff, clr_m_ff;
   logic signed [sqmm_pkg::PROD_W-1:0] prod_ff;
   logic [sqmm_pkg::PROD_W-1:0]      acc_ff, acc_in;
   logic                             rsp_tvalid_ff, rsp_tvalid_in;
   logic [sqmm_pkg::RSP_DATA_W-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [sqmm_pkg::RSP_USER_W-1:0]  rsp_tuser_ff, rsp_tuser_in;
   logic                             rsp_tlast_ff, rsp_tlast_in;

   assign rd_a_addr = AW'(row) * AW'(size) + AW'(k);
   assign rd_b_addr = AW'(k) * AW'(size) + AW'(col);

   // stores: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cmd.wr_first) begin
         first_store[wr_addr] <= wr_data;
      end
      if (cmd.wr_second) begin
         second_store[wr_addr] <= wr_data;
      end
      a_q_ff <= first_store[rd_a_addr];
      b_q_ff <= second_store[rd_b_addr];
   end

   always_comb begin
      acc_in = acc_ff;
      if (mul_vld_ff) begin
         acc_in = (clr_m_ff ? '0 : acc_ff) + sqmm_pkg::PROD_W'(prod_ff);
      end
   end

   assign sts.out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
         rsp_tlast_in  = cmd.emit_last;
         rsp_tuser_in  = sqmm_pkg::RSP_USER_W'(cmd.emit_error);
         if (cmd.emit_error) begin
            rsp_tdata_in = '0;
         end else begin
            rsp_tdata_in = {PAD_W'(0), sqmm_pkg::IDX_OUT_W'(col),
                            sqmm_pkg::IDX_OUT_W'(row), acc_ff};
         end
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= $signed(a_q_ff) * $signed(b_q_ff);
      clr_q_ff     <= cmd.acc_clear;
      clr_m_ff     <= clr_q_ff;
      acc_ff       <= acc_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
      if (reset) begin
         rd_vld_ff     <= 1'b0;
         mul_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_vld_ff     <= cmd.issue;
         mul_vld_ff    <= rd_vld_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

/* bench/square_matrix_multiply_tb.sv */
// square_matrix_multiply_tb: self-checking bench for the streaming square matrix multiplier.
// Depends on sqmm_pkg and square_matrix_multiply; keeps its own product predictor.
module square_matrix_multiply_tb;

   localparam int MAX_SIZE      = 4;
   localparam int STORE_DEPTH   = MAX_SIZE * MAX_SIZE;
   localparam int RANDOM_ITEMS  = 140;
   localparam int STALL_LIMIT   = 2000;
   // quiet time before a size write; covers drain and result register load
   localparam int SETTLE_CYCLES = sqmm_pkg::DRAIN_CYCLES + 8;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mix_type;

   typedef struct {
      logic [sqmm_pkg::PROD_W-1:0]    product;
      logic [sqmm_pkg::IDX_OUT_W-1:0] row;
      logic [sqmm_pkg::IDX_OUT_W-1:0] column;
      logic                           size_error;
      logic                           last;
   } product_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            csr_we     = 1'b0;
   logic [sqmm_pkg::CSR_IDX_W-1:0]  csr_index  = sqmm_pkg::CSR_ROW_COUNT;
   logic [sqmm_pkg::CSR_W-1:0]      csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [sqmm_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // [15:0] element_value
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   // [31:0] product_value, [33:32] result_row, [35:34] result_column, [39:36] zero
   logic [sqmm_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [sqmm_pkg::RSP_USER_W-1:0] rsp_tuser;          // [0] size_error
   logic                            rsp_tlast;

   // bench copy of the matrix stores, load position and size registers
   logic signed [sqmm_pkg::ELEM_W-1:0] a_matrix [STORE_DEPTH];
   logic signed [sqmm_pkg::ELEM_W-1:0] b_matrix [STORE_DEPTH];
   int                                 load_count      = 0;
   logic [sqmm_pkg::CSR_W-1:0]         rows_setting    = sqmm_pkg::ROW_COUNT_RESET;
   logic [sqmm_pkg::CSR_W-1:0]         columns_setting = sqmm_pkg::COLUMN_COUNT_RESET;

   logic [sqmm_pkg::ELEM_W-1:0] pending_elements [$];
   product_type                 expected_products [$];

   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   int error_count      = 0;
   int elements_queued  = 0;
   int elements_taken   = 0;
   int products_seen    = 0;
   int size_errors_seen = 0;
   int settings_written = 0;
   int quiet_cycles     = 0;

   square_matrix_multiply #(
      .MAX_SIZE (MAX_SIZE)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // A zero size acts as one, anything above the maximum acts as the maximum.
   function automatic int effective_size(input logic [sqmm_pkg::CSR_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_SIZE) return MAX_SIZE;
      return int'(value);
   endfunction

   // Store one accepted element; on the last B element queue the products
   // (or the single size error transaction) that the block must return.
   function automatic void absorb_element(input logic [sqmm_pkg::ELEM_W-1:0] elem);
      int          rows;
      int          cols;
      int          total;
      int          acc;
      product_type res;
      rows  = effective_size(rows_setting);
      cols  = effective_size(columns_setting);
      total = rows * cols;
      if (load_count >= 2 * total) load_count = 0;
      if (load_count < total) a_matrix[load_count] = elem;
      else b_matrix[load_count - total] = elem;
      load_count++;
      if (load_count < 2 * total) return;
      load_count = 0;
      if (rows != cols) begin
         res = '{product: '0, row: '0, column: '0, size_error: 1'b1, last: 1'b1};
         expected_products.push_back(res);
         return;
      end
      for (int i = 0; i < rows; i++) begin
         for (int j = 0; j < cols; j++) begin
            acc = 0;
            // int arithmetic wraps at 32 bits, as the block does
            for (int k = 0; k < cols; k++) begin
               acc += int'(a_matrix[i * cols + k]) * int'(b_matrix[k * cols + j]);
            end
            res.product    = acc;
            res.row        = sqmm_pkg::IDX_OUT_W'(i);
            res.column     = sqmm_pkg::IDX_OUT_W'(j);
            res.size_error = 1'b0;
            res.last       = (i == rows - 1) && (j == cols - 1);
            expected_products.push_back(res);
         end
      end
   endfunction

   function automatic void check_field(input string name,
                                       input logic [sqmm_pkg::PROD_W-1:0] want,
                                       input logic [sqmm_pkg::PROD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Bias toward the corners of the signed range so wrap and sign cases show up.
   function automatic logic [sqmm_pkg::ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return sqmm_pkg::ELEM_W'($urandom);
      endcase
   endfunction

   task automatic push_element(input logic [sqmm_pkg::ELEM_W-1:0] elem);
      pending_elements.push_back(elem);
      elements_queued++;
   endtask

   // Write both size registers; each write restarts loading in the block.
   task automatic write_sizes(input logic [sqmm_pkg::CSR_W-1:0] rows,
                              input logic [sqmm_pkg::CSR_W-1:0] cols);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= sqmm_pkg::CSR_ROW_COUNT;
      csr_wdata <= rows;
      rows_setting = rows;
      load_count   = 0;
      @(posedge clock);
      csr_index <= sqmm_pkg::CSR_COLUMN_COUNT;
      csr_wdata <= cols;
      columns_setting = cols;
      @(posedge clock);
      csr_we <= 1'b0;
      settings_written++;
   endtask

   // Hold until every queued element is taken and every product has come back,
   // then let the pipeline drain before touching the registers.
   task automatic settle();
      while (elements_taken != elements_queued || expected_products.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: advance to the next element once the current transaction is taken;
   // idle at random while the sender mix asks for it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_element(req_tdata);
            elements_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_elements.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_elements.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each result transaction with the oldest expected product.
   always @(posedge clock) begin
      product_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            products_seen++;
            if (rsp_tuser[0]) size_errors_seen++;
            if (expected_products.size() == 0) begin
               $error("result transaction with nothing pending: tdata 'h%0h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_products.pop_front();
               check_field("product_value", want.product, rsp_tdata[31:0]);
               check_field("result_row", sqmm_pkg::PROD_W'(want.row),
                           sqmm_pkg::PROD_W'(rsp_tdata[33:32]));
               check_field("result_column", sqmm_pkg::PROD_W'(want.column),
                           sqmm_pkg::PROD_W'(rsp_tdata[35:34]));
               check_field("size_error", sqmm_pkg::PROD_W'(want.size_error),
                           sqmm_pkg::PROD_W'(rsp_tuser[0]));
               check_field("last_of_run", sqmm_pkg::PROD_W'(want.last),
                           sqmm_pkg::PROD_W'(rsp_tlast));
               check_field("tdata_padding", '0, sqmm_pkg::PROD_W'(rsp_tdata[39:36]));
            end
         end
         // stall at random while the receiver mix asks for it
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: drop the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                         phase;
      int                         total;
      int                         runs;
      int                         random_count;
      idle_mix_type               mix;
      logic [sqmm_pkg::CSR_W-1:0] r_set;
      logic [sqmm_pkg::CSR_W-1:0] c_set;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 1x1: most negative squared, most positive squared, zero times minus one
      write_sizes(3'd1, 3'd1);
      push_element(16'h8000);
      push_element(16'h8000);
      push_element(16'h7FFF);
      push_element(16'h7FFF);
      push_element(16'h0000);
      push_element(16'hFFFF);
      settle();

      // 2x2 of the most negative value: each sum reaches 2^31 and wraps
      write_sizes(3'd2, 3'd2);
      repeat (8) push_element(16'h8000);
      settle();

      // non-square size: one error transaction only
      write_sizes(3'd1, 3'd2);
      push_element(16'h0001);
      push_element(16'h7FFF);
      push_element(16'h8000);
      push_element(16'hFFFF);
      settle();

      // zero sizes act as 1x1
      write_sizes(3'd0, 3'd0);
      push_element(16'h0001);
      push_element(16'hFFFF);
      settle();

      // abandon a half-loaded 2x2; the size write restarts loading
      write_sizes(3'd2, 3'd2);
      push_element(16'h1234);
      push_element(16'h8000);
      push_element(16'h7FFF);
      settle();
      write_sizes(3'd1, 3'd1);
      push_element(16'hFFFF);
      push_element(16'h8000);
      settle();

      // random phases: mostly whole matrix pairs, some cut short
      random_count = 0;
      phase        = 0;
      while (random_count < RANDOM_ITEMS) begin
         mix = idle_mix_type'(phase % 4);
         case (mix)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 50; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 50; end
            IDLE_BOTH:     begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase

         if (phase == 0) begin
            // sizes above the maximum, all register bits high on one
            r_set = 3'd7;
            c_set = 3'd5;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  r_set = sqmm_pkg::CSR_W'($urandom_range(1, 3));
                  c_set = r_set;
               end
               6: begin
                  r_set = sqmm_pkg::CSR_W'($urandom_range(4, 7));
                  c_set = sqmm_pkg::CSR_W'($urandom_range(4, 7));
               end
               7: begin
                  r_set = 3'd0;
                  c_set = sqmm_pkg::CSR_W'($urandom_range(0, 1));
               end
               default: begin
                  r_set = sqmm_pkg::CSR_W'($urandom_range(1, 4));
                  do c_set = sqmm_pkg::CSR_W'($urandom_range(1, 4)); while (c_set == r_set);
               end
            endcase
         end
         write_sizes(r_set, c_set);

         total = 2 * effective_size(r_set) * effective_size(c_set);
         runs  = (total >= 18) ? 1 : $urandom_range(1, 3);
         for (int n = 0; n < runs; n++) begin
            for (int e = 0; e < total; e++) begin
               push_element(pick_element());
               random_count++;
            end
         end
         // broken sequence: leave a partial load for the next write to discard
         if ($urandom_range(0, 3) == 0) begin
            for (int e = $urandom_range(1, total - 1); e > 0; e--) begin
               push_element(pick_element());
               random_count++;
            end
         end
         settle();
         phase++;
      end

      $display("Covered %0d elements in, %0d results out (%0d size errors), %0d size settings",
               elements_taken, products_seen, size_errors_seen, settings_written);
      $display("Random part: %0d phases rotating through no idling, sender, receiver and both",
               phase);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
design/sqmm_pkg.sv
design/sqmm_ctrl.sv
design/sqmm_dp.sv
design/square_matrix_multiply.sv
bench/square_matrix_multiply_tb.sv
